>>> rtl/rpp_pkg.sv
// ============================================================================
// rpp_pkg: shared types, widths and tables for the rotate/project unit
// Fixed-point widths of every pipeline stage, the quarter-wave sine table
// and the sine/cosine evaluator.
// ============================================================================
`default_nettype none

package rpp_pkg;

   localparam int COORD_BITS = 11;
   localparam int ANGLE_BITS = 12;

   localparam int RW = COORD_BITS + 11;             // rotated values, Q.8
   localparam int DW = RW + 2;                      // signed denominator
   localparam int DV = DW - 1;                      // divisor magnitude
   localparam int NW = RW + 13;                     // signed numerator
   localparam int QW = NW - 1;                      // numerator magnitude
   localparam int DIV_STEPS  = 5;
   localparam int DIV_STAGES = (QW + DIV_STEPS - 1) / DIV_STEPS;
   localparam int QP = DIV_STAGES * DIV_STEPS;      // padded quotient

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FOCAL    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_X = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_Y = 2'd2;

   localparam logic [11:0] FOCAL_RESET    = 12'd150;
   localparam logic [9:0]  CENTER_X_RESET = 10'd120;
   localparam logic [9:0]  CENTER_Y_RESET = 10'd214;

   typedef logic signed [COORD_BITS-1:0]   coord_type;
   typedef logic [ANGLE_BITS-1:0]          angle_type;
   typedef logic signed [15:0]             trig_type;
   typedef logic signed [COORD_BITS+15:0]  prod1_type;
   typedef logic signed [COORD_BITS+16:0]  sum1_type;
   typedef logic signed [RW-1:0]           rot_val_type;
   typedef logic signed [COORD_BITS+7:0]   yq_type;
   typedef logic signed [RW+15:0]          prod2_type;
   typedef logic signed [RW+16:0]          sum2_type;
   typedef logic signed [DW-1:0]           denom_type;
   typedef logic signed [NW-1:0]           num_type;
   typedef logic [QP-1:0]                  quot_type;
   typedef logic [DV-1:0]                  div_type;
   typedef logic signed [15:0]             screen_type;
   typedef logic signed [19:0]             depth_type;

   typedef struct packed {
      rot_val_type x1;
      rot_val_type y2;
      rot_val_type z2;
   } rpp_rot_type;

   typedef struct packed {
      logic [11:0] focal_distance;
      logic [9:0]  center_x;
      logic [9:0]  center_y;
   } rpp_cfg_type;

   typedef struct packed {
      screen_type screen_x;
      screen_type screen_y;
      depth_type  rotated_depth;
      logic       behind_viewer;
   } rpp_result_type;

   localparam logic [14:0] QUARTER_SINE [33] = '{
      15'd0,     15'd804,   15'd1606,  15'd2404,  15'd3196,  15'd3981,  15'd4756,
      15'd5520,  15'd6270,  15'd7005,  15'd7723,  15'd8423,  15'd9102,  15'd9760,
      15'd10394, 15'd11003, 15'd11585, 15'd12140, 15'd12665, 15'd13160, 15'd13623,
      15'd14053, 15'd14449, 15'd14811, 15'd15137, 15'd15426, 15'd15679, 15'd15893,
      15'd16069, 15'd16207, 15'd16305, 15'd16364, 15'd16384
   };

   // Q1.14 sine of a 16-bit phase, table plus linear interpolation
   function automatic trig_type sine_q14(input logic [15:0] phase);
      logic [1:0]  quad;
      logic [14:0] r;
      logic [5:0]  idx;
      logic [5:0]  idx_n;
      logic [8:0]  frac;
      logic [10:0] d;
      logic [19:0] prod;
      logic [14:0] mag;
      quad  = phase[15:14];
      r     = {1'b0, phase[13:0]};
      if (quad[0]) begin
         r = 15'd16384 - r;
      end
      idx   = r[14:9];
      frac  = r[8:0];
      idx_n = idx + 6'd1;
      d     = '0;
      prod  = '0;
      if (idx[5]) begin
         mag = QUARTER_SINE[32];
      end else begin
         d    = 11'(QUARTER_SINE[idx_n] - QUARTER_SINE[idx]);
         prod = 20'(d) * 20'(frac) + 20'd256;
         mag  = QUARTER_SINE[idx] + 15'(prod[19:9]);
      end
      return quad[1] ? -trig_type'({1'b0, mag}) : trig_type'({1'b0, mag});
   endfunction

endpackage

`default_nettype wire

>>> rtl/rpp_req_if.sv
// ============================================================================
// rpp_req_if: point transaction channel
// One 3D point and two rotation angles per transaction.
// ============================================================================
`default_nettype none

interface rpp_req_if;
   logic                valid;
   logic                ready;
   rpp_pkg::coord_type  point_x;
   rpp_pkg::coord_type  point_y;
   rpp_pkg::coord_type  point_z;
   rpp_pkg::angle_type  angle_about_x;
   rpp_pkg::angle_type  angle_about_y;

   modport source (output valid, point_x, point_y, point_z, angle_about_x, angle_about_y,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_z, angle_about_x, angle_about_y,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/rpp_rsp_if.sv
// ============================================================================
// rpp_rsp_if: projected point transaction channel
// Screen coordinates, rotated depth and behind-viewer flag.
// ============================================================================
`default_nettype none

interface rpp_rsp_if;
   logic                 valid;
   logic                 ready;
   rpp_pkg::screen_type  screen_x;
   rpp_pkg::screen_type  screen_y;
   rpp_pkg::depth_type   rotated_depth;
   logic                 behind_viewer;

   modport source (output valid, screen_x, screen_y, rotated_depth, behind_viewer,
                   input ready);
   modport sink   (input valid, screen_x, screen_y, rotated_depth, behind_viewer,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/rotate_project_point_unit.sv
// ============================================================================
// rotate_project_point_unit: 3D point rotation and perspective projection
// Rotates each point about Y then X and projects it onto the screen.
// ============================================================================
// Usage:
//   req_chan carries one point (x, y, z) and two 12-bit angles per
//   transaction; rsp_chan returns screen x/y, rotated depth (Q.8) and the
//   behind-viewer flag, one result per point, in order.
//   csr_wr_en/csr_index/csr_wr_data write focal distance (0), center x (1)
//   and center y (2); write only while no transaction is in flight.
// Timing:
//   The path from accept to rsp_chan.valid runs through 5 rotation stages,
//   2 projection setup stages, 7 divider stages (5 quotient bits each) and
//   the output register. One transaction per cycle is sustained while
//   rsp_chan.ready stays high; the divider pipeline sets the depth.
// Reset:
//   Synchronous, active high. Clears all valid bits and loads focal 150,
//   center (120, 214).
// Stall:
//   When rsp_chan.ready is low the result is held in the output register and
//   one more is caught in a skid entry; the whole pipeline then freezes and
//   req_chan.ready drops until the skid entry drains. Nothing is lost.
// ============================================================================
`default_nettype none

module rotate_project_point_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   rpp_req_if.sink                                     req_chan,
   rpp_rsp_if.source                                   rsp_chan,
   input  wire logic                                   csr_wr_en,
   input  wire logic [rpp_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [rpp_pkg::CSR_DATA_BITS-1:0]      csr_wr_data
);

   rpp_pkg::rpp_cfg_type    cfg_ff;
   logic                    en;
   logic                    rot_v;
   rpp_pkg::rpp_rot_type    rot;
   logic                    prj_v;
   rpp_pkg::rpp_result_type prj_res;
   rpp_pkg::rpp_result_type out_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_distance <= rpp_pkg::FOCAL_RESET;
         cfg_ff.center_x       <= rpp_pkg::CENTER_X_RESET;
         cfg_ff.center_y       <= rpp_pkg::CENTER_Y_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rpp_pkg::REG_FOCAL:    cfg_ff.focal_distance <= csr_wr_data;
            rpp_pkg::REG_CENTER_X: cfg_ff.center_x       <= csr_wr_data[9:0];
            rpp_pkg::REG_CENTER_Y: cfg_ff.center_y       <= csr_wr_data[9:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = en;

   rpp_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_x      (req_chan.point_x),
      .in_y      (req_chan.point_y),
      .in_z      (req_chan.point_z),
      .in_ax     (req_chan.angle_about_x),
      .in_ay     (req_chan.angle_about_y),
      .out_valid (rot_v),
      .out_rot   (rot)
   );

   rpp_project u_project (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (rot_v),
      .in_rot     (rot),
      .cfg        (cfg_ff),
      .out_valid  (prj_v),
      .out_result (prj_res)
   );

   rpp_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prj_v),
      .in_data   (prj_res),
      .en        (en),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_res)
   );

   assign rsp_chan.screen_x      = out_res.screen_x;
   assign rsp_chan.screen_y      = out_res.screen_y;
   assign rsp_chan.rotated_depth = out_res.rotated_depth;
   assign rsp_chan.behind_viewer = out_res.behind_viewer;

endmodule

`default_nettype wire

>>> rtl/rpp_rotate.sv
// ============================================================================
// rpp_rotate: five-stage rotation pipeline
// Sine/cosine lookup, rotation about Y, then rotation about X, with a
// register after every multiplier bank.
// ============================================================================
`default_nettype none

module rpp_rotate (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire rpp_pkg::coord_type    in_x,
   input  wire rpp_pkg::coord_type    in_y,
   input  wire rpp_pkg::coord_type    in_z,
   input  wire rpp_pkg::angle_type    in_ax,
   input  wire rpp_pkg::angle_type    in_ay,
   output logic                       out_valid,
   output rpp_pkg::rpp_rot_type       out_rot
);

   logic [4:0] v_ff;

   logic [15:0] ph_x;
   logic [15:0] ph_y;

   rpp_pkg::coord_type s1_x_ff, s1_y_ff, s1_z_ff;
   rpp_pkg::trig_type  s1_sx_ff, s1_cx_ff, s1_sy_ff, s1_cy_ff;

   rpp_pkg::prod1_type s2_xcy_ff, s2_zsy_ff, s2_xsy_ff, s2_zcy_ff;
   rpp_pkg::coord_type s2_y_ff;
   rpp_pkg::trig_type  s2_sx_ff, s2_cx_ff;

   rpp_pkg::sum1_type    sum_x1, sum_z1;
   rpp_pkg::rot_val_type s3_x1_ff, s3_z1_ff;
   rpp_pkg::coord_type   s3_y_ff;
   rpp_pkg::trig_type    s3_sx_ff, s3_cx_ff;

   rpp_pkg::yq_type      yq;
   rpp_pkg::prod2_type   s4_a_ff, s4_b_ff, s4_c_ff, s4_d_ff;
   rpp_pkg::rot_val_type s4_x1_ff;

   rpp_pkg::sum2_type    sum_y2, sum_z2;
   rpp_pkg::rot_val_type s5_x1_ff, s5_y2_ff, s5_z2_ff;

   assign ph_x = 16'(in_ax) << (16 - rpp_pkg::ANGLE_BITS);
   assign ph_y = 16'(in_ay) << (16 - rpp_pkg::ANGLE_BITS);

   assign sum_x1 = rpp_pkg::sum1_type'(s2_xcy_ff) + rpp_pkg::sum1_type'(s2_zsy_ff)
                 + rpp_pkg::sum1_type'(32);
   assign sum_z1 = rpp_pkg::sum1_type'(s2_zcy_ff) - rpp_pkg::sum1_type'(s2_xsy_ff)
                 + rpp_pkg::sum1_type'(32);

   assign yq = rpp_pkg::yq_type'(s3_y_ff) <<< 8;

   assign sum_y2 = rpp_pkg::sum2_type'(s4_a_ff) - rpp_pkg::sum2_type'(s4_b_ff)
                 + rpp_pkg::sum2_type'(8192);
   assign sum_z2 = rpp_pkg::sum2_type'(s4_c_ff) + rpp_pkg::sum2_type'(s4_d_ff)
                 + rpp_pkg::sum2_type'(8192);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff  <= in_x;
         s1_y_ff  <= in_y;
         s1_z_ff  <= in_z;
         s1_sx_ff <= rpp_pkg::sine_q14(ph_x);
         s1_cx_ff <= rpp_pkg::sine_q14(ph_x + 16'd16384);
         s1_sy_ff <= rpp_pkg::sine_q14(ph_y);
         s1_cy_ff <= rpp_pkg::sine_q14(ph_y + 16'd16384);

         s2_xcy_ff <= rpp_pkg::prod1_type'(s1_x_ff) * rpp_pkg::prod1_type'(s1_cy_ff);
         s2_zsy_ff <= rpp_pkg::prod1_type'(s1_z_ff) * rpp_pkg::prod1_type'(s1_sy_ff);
         s2_xsy_ff <= rpp_pkg::prod1_type'(s1_x_ff) * rpp_pkg::prod1_type'(s1_sy_ff);
         s2_zcy_ff <= rpp_pkg::prod1_type'(s1_z_ff) * rpp_pkg::prod1_type'(s1_cy_ff);
         s2_y_ff   <= s1_y_ff;
         s2_sx_ff  <= s1_sx_ff;
         s2_cx_ff  <= s1_cx_ff;

         s3_x1_ff <= rpp_pkg::rot_val_type'(sum_x1 >>> 6);
         s3_z1_ff <= rpp_pkg::rot_val_type'(sum_z1 >>> 6);
         s3_y_ff  <= s2_y_ff;
         s3_sx_ff <= s2_sx_ff;
         s3_cx_ff <= s2_cx_ff;

         s4_a_ff  <= rpp_pkg::prod2_type'(yq) * rpp_pkg::prod2_type'(s3_cx_ff);
         s4_b_ff  <= rpp_pkg::prod2_type'(s3_z1_ff) * rpp_pkg::prod2_type'(s3_sx_ff);
         s4_c_ff  <= rpp_pkg::prod2_type'(yq) * rpp_pkg::prod2_type'(s3_sx_ff);
         s4_d_ff  <= rpp_pkg::prod2_type'(s3_z1_ff) * rpp_pkg::prod2_type'(s3_cx_ff);
         s4_x1_ff <= s3_x1_ff;

         s5_x1_ff <= s4_x1_ff;
         s5_y2_ff <= rpp_pkg::rot_val_type'(sum_y2 >>> 14);
         s5_z2_ff <= rpp_pkg::rot_val_type'(sum_z2 >>> 14);
      end
   end

   assign out_valid  = v_ff[4];
   assign out_rot.x1 = s5_x1_ff;
   assign out_rot.y2 = s5_y2_ff;
   assign out_rot.z2 = s5_z2_ff;

endmodule

`default_nettype wire

>>> rtl/rpp_divider.sv
// ============================================================================
// rpp_divider: pipelined unsigned restoring divider
// DIV_STEPS quotient bits per stage, DIV_STAGES stages, one division
// started per enabled cycle.
// ============================================================================
`default_nettype none

module rpp_divider (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire rpp_pkg::quot_type  dividend,
   input  wire rpp_pkg::div_type   divisor,
   output rpp_pkg::quot_type       quotient
);

   rpp_pkg::div_type  rem_ff [rpp_pkg::DIV_STAGES];
   rpp_pkg::quot_type dq_ff  [rpp_pkg::DIV_STAGES];
   rpp_pkg::div_type  dv_ff  [rpp_pkg::DIV_STAGES];

   for (genvar s = 0; s < rpp_pkg::DIV_STAGES; s++) begin : g_stage
      rpp_pkg::div_type  rem_src;
      rpp_pkg::quot_type dq_src;
      rpp_pkg::div_type  dv_src;
      rpp_pkg::div_type  rem_in;
      rpp_pkg::quot_type dq_in;

      if (s == 0) begin : g_first
         assign rem_src = '0;
         assign dq_src  = dividend;
         assign dv_src  = divisor;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign dq_src  = dq_ff[s-1];
         assign dv_src  = dv_ff[s-1];
      end

      always_comb begin : step
         logic [rpp_pkg::DV:0] t;
         rpp_pkg::div_type     r;
         rpp_pkg::quot_type    q;
         r = rem_src;
         q = dq_src;
         t = '0;
         for (int k = 0; k < rpp_pkg::DIV_STEPS; k++) begin
            t = {r, q[rpp_pkg::QP-1]};
            q = {q[rpp_pkg::QP-2:0], 1'b0};
            if (t >= {1'b0, dv_src}) begin
               t    = t - {1'b0, dv_src};
               q[0] = 1'b1;
            end
            r = t[rpp_pkg::DV-1:0];
         end
         rem_in = r;
         dq_in  = q;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            dq_ff[s]  <= dq_in;
            dv_ff[s]  <= dv_src;
         end
      end
   end

   assign quotient = dq_ff[rpp_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

>>> rtl/rpp_project.sv
// ============================================================================
// rpp_project: perspective projection pipeline
// Numerators and denominator, sign split, two pipelined dividers, then
// sign restore, centre offset and saturation.
// ============================================================================
`default_nettype none

module rpp_project (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire rpp_pkg::rpp_rot_type  in_rot,
   input  wire rpp_pkg::rpp_cfg_type  cfg,
   output logic                       out_valid,
   output rpp_pkg::rpp_result_type    out_result
);

   typedef struct packed {
      logic                behind;
      logic                neg_x;
      logic                neg_y;
      rpp_pkg::depth_type  depth;
   } side_type;

   logic                p1_v_ff;
   rpp_pkg::num_type    p1_nx_ff, p1_ny_ff;
   logic                p1_x1_neg_ff, p1_y2_neg_ff;
   rpp_pkg::denom_type  p1_den_ff;
   rpp_pkg::depth_type  p1_depth_ff;
   rpp_pkg::denom_type  den_in;
   rpp_pkg::denom_type  z2_wide;
   rpp_pkg::depth_type  depth_in;
   rpp_pkg::num_type    focal_s;

   logic                p2_v_ff;
   side_type            p2_side_ff;
   rpp_pkg::quot_type   p2_mx_ff, p2_my_ff;
   rpp_pkg::div_type    p2_dv_ff;
   logic                behind_in;
   rpp_pkg::num_type    ax, ay;

   logic                dv_v_ff   [rpp_pkg::DIV_STAGES];
   side_type            dv_side_ff[rpp_pkg::DIV_STAGES];
   rpp_pkg::quot_type   qx, qy;
   side_type            last_side;

   function automatic rpp_pkg::screen_type sat_screen(input rpp_pkg::quot_type q,
                                                      input logic neg,
                                                      input logic behind,
                                                      input logic [9:0] ctr);
      logic               big;
      logic signed [18:0] v;
      big = |q[rpp_pkg::QP-1:17];
      v   = {2'b00, q[16:0]};
      if (neg) begin
         v = -v;
      end
      v = v + $signed({9'b0, ctr});
      if (behind || big) begin
         return neg ? 16'sh8000 : 16'sh7fff;
      end else if (v > 19'sd32767) begin
         return 16'sh7fff;
      end else if (v < -19'sd32768) begin
         return 16'sh8000;
      end else begin
         return v[15:0];
      end
   endfunction

   assign focal_s = rpp_pkg::num_type'($signed({1'b0, cfg.focal_distance}));
   assign z2_wide = rpp_pkg::denom_type'(in_rot.z2);
   assign den_in  = rpp_pkg::denom_type'($signed({1'b0, cfg.focal_distance, 8'b0})) + z2_wide;

   always_comb begin
      if (z2_wide > rpp_pkg::denom_type'(524287)) begin
         depth_in = 20'sh7ffff;
      end else if (z2_wide < -rpp_pkg::denom_type'(524288)) begin
         depth_in = 20'sh80000;
      end else begin
         depth_in = rpp_pkg::depth_type'(z2_wide);
      end
   end

   assign behind_in = p1_den_ff[rpp_pkg::DW-1] || (p1_den_ff == '0);
   assign ax = p1_nx_ff[rpp_pkg::NW-1] ? -p1_nx_ff : p1_nx_ff;
   assign ay = p1_ny_ff[rpp_pkg::NW-1] ? -p1_ny_ff : p1_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         for (int s = 0; s < rpp_pkg::DIV_STAGES; s++) begin
            dv_v_ff[s] <= 1'b0;
         end
      end else if (en) begin
         p1_v_ff    <= in_valid;
         p2_v_ff    <= p1_v_ff;
         dv_v_ff[0] <= p2_v_ff;
         for (int s = 1; s < rpp_pkg::DIV_STAGES; s++) begin
            dv_v_ff[s] <= dv_v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_nx_ff     <= rpp_pkg::num_type'(in_rot.x1) * focal_s;
         p1_ny_ff     <= rpp_pkg::num_type'(in_rot.y2) * focal_s;
         p1_x1_neg_ff <= in_rot.x1[rpp_pkg::RW-1];
         p1_y2_neg_ff <= in_rot.y2[rpp_pkg::RW-1];
         p1_den_ff    <= den_in;
         p1_depth_ff  <= depth_in;

         p2_side_ff.behind <= behind_in;
         p2_side_ff.neg_x  <= p1_x1_neg_ff;
         p2_side_ff.neg_y  <= p1_y2_neg_ff;
         p2_side_ff.depth  <= p1_depth_ff;
         p2_mx_ff <= rpp_pkg::quot_type'($unsigned(ax));
         p2_my_ff <= rpp_pkg::quot_type'($unsigned(ay));
         p2_dv_ff <= behind_in ? rpp_pkg::div_type'(1) : rpp_pkg::div_type'(p1_den_ff);

         dv_side_ff[0] <= p2_side_ff;
         for (int s = 1; s < rpp_pkg::DIV_STAGES; s++) begin
            dv_side_ff[s] <= dv_side_ff[s-1];
         end
      end
   end

   rpp_divider u_div_x (
      .clock    (clock),
      .en       (en),
      .dividend (p2_mx_ff),
      .divisor  (p2_dv_ff),
      .quotient (qx)
   );

   rpp_divider u_div_y (
      .clock    (clock),
      .en       (en),
      .dividend (p2_my_ff),
      .divisor  (p2_dv_ff),
      .quotient (qy)
   );

   assign last_side = dv_side_ff[rpp_pkg::DIV_STAGES-1];
   assign out_valid = dv_v_ff[rpp_pkg::DIV_STAGES-1];

   assign out_result.screen_x      = sat_screen(qx, last_side.neg_x, last_side.behind,
                                                cfg.center_x);
   assign out_result.screen_y      = sat_screen(qy, last_side.neg_y, last_side.behind,
                                                cfg.center_y);
   assign out_result.rotated_depth = last_side.depth;
   assign out_result.behind_viewer = last_side.behind;

endmodule

`default_nettype wire

>>> rtl/rpp_out_skid.sv
// ============================================================================
// rpp_out_skid: output register with skid entry
// Holds results while the receiver stalls; the pipeline enable is driven
// from a register, so ready never depends combinationally on the receiver.
// ============================================================================
`default_nettype none

module rpp_out_skid (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire rpp_pkg::rpp_result_type  in_data,
   output logic                          en,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output rpp_pkg::rpp_result_type       out_data
);

   logic                    main_v_ff;
   logic                    skid_v_ff;
   rpp_pkg::rpp_result_type main_ff;
   rpp_pkg::rpp_result_type skid_ff;
   logic                    push;
   logic                    pop;

   assign en   = !skid_v_ff;
   assign push = en && in_valid;
   assign pop  = main_v_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_v_ff && !pop) begin
            skid_v_ff <= 1'b1;
         end else begin
            main_v_ff <= 1'b1;
         end
      end else if (pop) begin
         main_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_v_ff && !pop) begin
            skid_ff <= in_data;
         end else begin
            main_ff <= in_data;
         end
      end
   end

   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> main_v_ff)
      else $error("skid entry holds data while output register is empty");

   a_overflow_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && main_v_ff && !pop) |=> skid_v_ff)
      else $error("result pushed into full output register was dropped");

   a_skid_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(main_v_ff && !out_ready))
      else $error("skid entry filled without a receiver stall");

   a_skid_drains_first: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && pop) |=> (main_v_ff && !skid_v_ff))
      else $error("skid entry not moved to output register on transaction");

endmodule

`default_nettype wire
